// File: design/trd_pkg.sv
package trd_pkg;

   // result kinds (travel on rsp_tuser)
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
   localparam logic [2:0] ERR_BAD_SIZE  = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;

   // file type codes found in header byte 2
   localparam logic [7:0] TYPE_RAW_CODE = 8'd2;
   localparam logic [7:0] TYPE_RLE_CODE = 8'd10;

   // type match flags: bit0 raw still possible, bit1 rle still possible
   localparam logic [1:0] MATCH_BOTH = 2'b11;
   localparam logic [1:0] MATCH_RAW  = 2'b01;
   localparam logic [1:0] MATCH_RLE  = 2'b10;
   localparam logic [1:0] MATCH_NONE = 2'b00;

   // header byte positions
   localparam logic [4:0] POS_TYPE       = 5'd2;
   localparam logic [4:0] POS_LAST_FIXED = 5'd11;
   localparam logic [4:0] POS_WIDTH_LO   = 5'd12;
   localparam logic [4:0] POS_WIDTH_HI   = 5'd13;
   localparam logic [4:0] POS_HEIGHT_LO  = 5'd14;
   localparam logic [4:0] POS_HEIGHT_HI  = 5'd15;
   localparam logic [4:0] POS_DEPTH      = 5'd16;

   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   // packet header: below this value starts a raw packet
   localparam logic [7:0] RLE_FLAG_VALUE = 8'd128;
   localparam logic [7:0] RLE_BIAS       = 8'd127;

   localparam int RSP_DATA_WIDTH = 80;

   typedef struct packed {
      logic [2:0]  error_code;
      logic        is_compressed;
      logic        has_alpha;
      logic [15:0] image_height;
      logic [15:0] image_width;
      logic [7:0]  repeat_count;
      logic [7:0]  alpha;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } rsp_fields_type;

endpackage

// File: design/tga_rle_image_decoder.sv
// channel | dir | tdata                  | tuser | tlast
// req     | in  | data_byte [7:0]        | -     | end_of_stream
// rsp     | out | packed result fields   | kind  | image_done
//
// one file byte is taken in every cycle; the state update and the result
// are worked out in the same cycle and land in the result register, so a
// result shows in the cycle after its byte is accepted. at most one result per
// byte. req_tready drops only while the result register holds a word that
// rsp_tready has not taken. reset (synchronous, active high) returns the
// parser to the start of a file; so does an accepted byte with tlast set.
module tga_rle_image_decoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_stream

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [trd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count,
   // [55:40] image_width, [71:56] image_height, [72] has_alpha,
   // [73] is_compressed, [76:74] error_code, [79:77] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // image_done
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_INFO,
      PH_PACKET,
      PH_PIXEL,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [1:0]  match_ff, match_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        four_ff, four_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic        packet_raw_ff, packet_raw_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic [1:0]  color_pos_ff, color_pos_in;
   logic [7:0]  colors_ff [4];
   logic [7:0]  colors_in [4];

   // result register
   logic                    rsp_valid_ff;
   trd_pkg::rsp_fields_type rsp_data_ff;
   logic [1:0]              rsp_kind_ff;
   logic                    rsp_done_ff;

   // result of the current byte
   logic                    res_valid;
   trd_pkg::rsp_fields_type res_data;
   logic [1:0]              res_kind;
   logic                    res_done;

   logic        accept;
   logic        compressed;
   logic        errored;
   logic [1:0]  match_v;
   logic [7:0]  cnt;
   logic [7:0]  rep;
   logic [31:0] pixels_after;
   logic [1:0]  last_pos;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign compressed = (match_ff == trd_pkg::MATCH_RLE);

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      match_in       = match_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      four_in        = four_ff;
      pixels_left_in = pixels_left_ff;
      packet_raw_in  = packet_raw_ff;
      packet_left_in = packet_left_ff;
      color_pos_in   = color_pos_ff;
      colors_in      = colors_ff;
      res_valid      = 1'b0;
      res_data       = '0;
      res_kind       = trd_pkg::KIND_HEADER;
      res_done       = 1'b0;
      errored        = 1'b0;
      match_v        = match_ff;
      cnt            = '0;
      rep            = '0;
      pixels_after   = pixels_left_ff;
      last_pos       = four_ff ? 2'd3 : 2'd2;

      unique case (phase_ff)
         PH_HEADER: begin
            // fixed 12-byte header: byte 2 picks the type, the rest are zero
            if (pos_ff == trd_pkg::POS_TYPE) begin
               if (req_tdata != trd_pkg::TYPE_RAW_CODE) match_v = match_v & trd_pkg::MATCH_RLE;
               if (req_tdata != trd_pkg::TYPE_RLE_CODE) match_v = match_v & trd_pkg::MATCH_RAW;
            end else if (req_tdata != 8'd0) begin
               match_v = trd_pkg::MATCH_NONE;
            end
            match_in = match_v;
            pos_in   = pos_ff + 5'd1;
            if (pos_ff >= trd_pkg::POS_LAST_FIXED) begin
               if (match_v != trd_pkg::MATCH_RAW && match_v != trd_pkg::MATCH_RLE) begin
                  res_valid           = 1'b1;
                  res_kind            = trd_pkg::KIND_ERROR;
                  res_data.error_code = trd_pkg::ERR_BAD_TYPE;
                  errored             = 1'b1;
                  phase_in            = PH_ERROR;
               end else begin
                  phase_in = PH_INFO;
               end
            end
         end
         PH_INFO: begin
            pos_in = pos_ff + 5'd1;
            case (pos_ff)
               trd_pkg::POS_WIDTH_LO:  width_in[7:0]   = req_tdata;
               trd_pkg::POS_WIDTH_HI:  width_in[15:8]  = req_tdata;
               trd_pkg::POS_HEIGHT_LO: height_in[7:0]  = req_tdata;
               trd_pkg::POS_HEIGHT_HI: height_in[15:8] = req_tdata;
               trd_pkg::POS_DEPTH: begin
                  four_in = (req_tdata == trd_pkg::DEPTH_32);
                  if (width_ff == 16'd0 || height_ff == 16'd0 ||
                      (req_tdata != trd_pkg::DEPTH_24 && req_tdata != trd_pkg::DEPTH_32)) begin
                     res_valid           = 1'b1;
                     res_kind            = trd_pkg::KIND_ERROR;
                     res_data.error_code = trd_pkg::ERR_BAD_SIZE;
                     errored             = 1'b1;
                     phase_in            = PH_ERROR;
                  end
               end
               default: begin
                  // descriptor byte: header is complete
                  pixels_left_in         = {16'd0, width_ff} * {16'd0, height_ff};
                  res_valid              = 1'b1;
                  res_kind               = trd_pkg::KIND_HEADER;
                  res_data.image_width   = width_ff;
                  res_data.image_height  = height_ff;
                  res_data.has_alpha     = four_ff;
                  res_data.is_compressed = compressed;
                  color_pos_in           = 2'd0;
                  if (compressed) begin
                     phase_in = PH_PACKET;
                  end else begin
                     packet_raw_in = 1'b1;
                     phase_in      = PH_PIXEL;
                  end
               end
            endcase
         end
         PH_PACKET: begin
            if (req_tdata < trd_pkg::RLE_FLAG_VALUE) begin
               cnt           = req_tdata + 8'd1;
               packet_raw_in = 1'b1;
            end else begin
               cnt           = req_tdata - trd_pkg::RLE_BIAS;
               packet_raw_in = 1'b0;
            end
            // overflow caught on the packet header, before any pixel goes out
            if ({24'd0, cnt} > pixels_left_ff) begin
               res_valid           = 1'b1;
               res_kind            = trd_pkg::KIND_ERROR;
               res_data.error_code = trd_pkg::ERR_OVERFLOW;
               errored             = 1'b1;
               phase_in            = PH_ERROR;
            end else begin
               packet_left_in = cnt;
               color_pos_in   = 2'd0;
               phase_in       = PH_PIXEL;
            end
         end
         PH_PIXEL: begin
            colors_in[color_pos_ff] = req_tdata;
            if (color_pos_ff < last_pos) begin
               color_pos_in = color_pos_ff + 2'd1;
            end else begin
               rep          = (compressed && !packet_raw_ff) ? packet_left_ff : 8'd1;
               color_pos_in = 2'd0;
               if ({24'd0, rep} > pixels_left_ff) rep = pixels_left_ff[7:0];
               pixels_after   = pixels_left_ff - {24'd0, rep};
               pixels_left_in = pixels_after;
               res_valid              = 1'b1;
               res_kind               = trd_pkg::KIND_PIXEL;
               res_data.image_width   = width_ff;
               res_data.image_height  = height_ff;
               res_data.has_alpha     = four_ff;
               res_data.is_compressed = compressed;
               // stored order is blue, green, red, alpha
               res_data.red           = colors_in[2];
               res_data.green         = colors_in[1];
               res_data.blue          = colors_in[0];
               res_data.alpha         = four_ff ? colors_in[3] : 8'd0;
               res_data.repeat_count  = rep;
               res_done               = (pixels_after == 32'd0);
               if (compressed) begin
                  if (packet_raw_ff && packet_left_ff != 8'd0) begin
                     packet_left_in = packet_left_ff - 8'd1;
                  end else begin
                     packet_left_in = 8'd0;
                  end
               end
               if (pixels_after == 32'd0) begin
                  phase_in = PH_DONE;
               end else if (compressed && packet_left_in == 8'd0) begin
                  phase_in = PH_PACKET;
               end
            end
         end
         PH_DONE, PH_ERROR: begin
            // trailing bytes are dropped
         end
         default: begin
         end
      endcase

      if (req_tlast) begin
         // last byte of the file: flag a short file, then start over
         if (!errored && phase_in != PH_DONE && phase_in != PH_ERROR) begin
            res_valid           = 1'b1;
            res_kind            = trd_pkg::KIND_ERROR;
            res_data            = '0;
            res_data.error_code = trd_pkg::ERR_TRUNCATED;
            res_done            = 1'b0;
         end
         phase_in       = PH_HEADER;
         pos_in         = 5'd0;
         match_in       = trd_pkg::MATCH_BOTH;
         width_in       = 16'd0;
         height_in      = 16'd0;
         four_in        = 1'b0;
         pixels_left_in = 32'd0;
         packet_raw_in  = 1'b0;
         packet_left_in = 8'd0;
         color_pos_in   = 2'd0;
         for (int i = 0; i < 4; i++) colors_in[i] = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         pos_ff         <= 5'd0;
         match_ff       <= trd_pkg::MATCH_BOTH;
         width_ff       <= 16'd0;
         height_ff      <= 16'd0;
         four_ff        <= 1'b0;
         pixels_left_ff <= 32'd0;
         packet_raw_ff  <= 1'b0;
         packet_left_ff <= 8'd0;
         color_pos_ff   <= 2'd0;
         for (int i = 0; i < 4; i++) colors_ff[i] <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            pos_ff         <= pos_in;
            match_ff       <= match_in;
            width_ff       <= width_in;
            height_ff      <= height_in;
            four_ff        <= four_in;
            pixels_left_ff <= pixels_left_in;
            packet_raw_ff  <= packet_raw_in;
            packet_left_ff <= packet_left_in;
            color_pos_ff   <= color_pos_in;
            colors_ff      <= colors_in;
         end
         if (accept && res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // payload, no reset needed
      if (accept && res_valid) begin
         rsp_data_ff <= res_data;
         rsp_kind_ff <= res_kind;
         rsp_done_ff <= res_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

// File: tb/sv/tga_decode_checker.sv
module tga_decode_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [trd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic [1:0]                         rsp_tuser,
   input  logic                               rsp_tlast,
   output int                                 mismatch_count,
   output int                                 words_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      ST_FILE_HEADER,
      ST_IMAGE_INFO,
      ST_PACKET_HEAD,
      ST_PIXEL_BYTES,
      ST_IMAGE_DONE,
      ST_REJECTED
   } parse_state_type;

   typedef struct packed {
      logic [1:0]              kind;
      trd_pkg::rsp_fields_type fields;
      logic                    done;
   } tga_result_type;

   // decoder state as predicted from the byte stream
   parse_state_type parse_state;
   logic [4:0]      hdr_pos;
   logic [1:0]      match_flags;
   logic [15:0]     img_width;
   logic [15:0]     img_height;
   logic            wide_pixels;
   logic [31:0]     pixels_left;
   logic            packet_raw;
   logic [7:0]      packet_left;
   logic [1:0]      color_pos;
   logic [7:0]      color_bytes [4];

   tga_result_type predicted_words [$];
   int             mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic clear_parser();
      parse_state = ST_FILE_HEADER;
      hdr_pos     = '0;
      match_flags = trd_pkg::MATCH_BOTH;
      img_width   = '0;
      img_height  = '0;
      wide_pixels = 1'b0;
      pixels_left = '0;
      packet_raw  = 1'b0;
      packet_left = '0;
      color_pos   = '0;
      foreach (color_bytes[i]) color_bytes[i] = '0;
   endtask

   function automatic tga_result_type error_word(input logic [2:0] code);
      tga_result_type w;
      w = '0;
      w.kind = trd_pkg::KIND_ERROR;
      w.fields.error_code = code;
      return w;
   endfunction

   function automatic tga_result_type image_word(input logic [1:0] kind);
      tga_result_type w;
      w = '0;
      w.kind = kind;
      w.fields.image_width   = img_width;
      w.fields.image_height  = img_height;
      w.fields.has_alpha     = wide_pixels;
      w.fields.is_compressed = (match_flags == trd_pkg::MATCH_RLE);
      return w;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic eos);
      tga_result_type res;
      logic           emit;
      logic           failed;
      logic           rle;
      logic [4:0]     pos;
      logic [31:0]    cnt;
      logic [31:0]    rep;
      logic [1:0]     last_pos;
      res    = '0;
      emit   = 1'b0;
      failed = 1'b0;
      rle    = (match_flags == trd_pkg::MATCH_RLE);
      case (parse_state)
         ST_FILE_HEADER: begin
            pos = hdr_pos;
            if (pos == trd_pkg::POS_TYPE) begin
               if (b != trd_pkg::TYPE_RAW_CODE) match_flags &= trd_pkg::MATCH_RLE;
               if (b != trd_pkg::TYPE_RLE_CODE) match_flags &= trd_pkg::MATCH_RAW;
            end else if (b != 8'd0) begin
               match_flags = trd_pkg::MATCH_NONE;
            end
            hdr_pos = pos + 5'd1;
            if (pos >= trd_pkg::POS_LAST_FIXED) begin
               if (match_flags != trd_pkg::MATCH_RAW && match_flags != trd_pkg::MATCH_RLE) begin
                  res = error_word(trd_pkg::ERR_BAD_TYPE);
                  emit = 1'b1;
                  failed = 1'b1;
                  parse_state = ST_REJECTED;
               end else begin
                  parse_state = ST_IMAGE_INFO;
               end
            end
         end
         ST_IMAGE_INFO: begin
            pos = hdr_pos;
            hdr_pos = pos + 5'd1;
            case (pos)
               trd_pkg::POS_WIDTH_LO:  img_width[7:0]   = b;
               trd_pkg::POS_WIDTH_HI:  img_width[15:8]  = b;
               trd_pkg::POS_HEIGHT_LO: img_height[7:0]  = b;
               trd_pkg::POS_HEIGHT_HI: img_height[15:8] = b;
               trd_pkg::POS_DEPTH: begin
                  wide_pixels = (b == trd_pkg::DEPTH_32);
                  if (img_width == '0 || img_height == '0 ||
                      (b != trd_pkg::DEPTH_24 && b != trd_pkg::DEPTH_32)) begin
                     res = error_word(trd_pkg::ERR_BAD_SIZE);
                     emit = 1'b1;
                     failed = 1'b1;
                     parse_state = ST_REJECTED;
                  end
               end
               default: begin
                  // descriptor byte: header is complete
                  pixels_left = {16'd0, img_width} * {16'd0, img_height};
                  res = image_word(trd_pkg::KIND_HEADER);
                  emit = 1'b1;
                  color_pos = '0;
                  if (rle) begin
                     parse_state = ST_PACKET_HEAD;
                  end else begin
                     packet_raw = 1'b1;
                     parse_state = ST_PIXEL_BYTES;
                  end
               end
            endcase
         end
         ST_PACKET_HEAD: begin
            if (b < trd_pkg::RLE_FLAG_VALUE) begin
               cnt = 32'(b) + 32'd1;
               packet_raw = 1'b1;
            end else begin
               cnt = 32'(b) - 32'(trd_pkg::RLE_BIAS);
               packet_raw = 1'b0;
            end
            if (cnt > pixels_left) begin
               res = error_word(trd_pkg::ERR_OVERFLOW);
               emit = 1'b1;
               failed = 1'b1;
               parse_state = ST_REJECTED;
            end else begin
               packet_left = cnt[7:0];
               color_pos = '0;
               parse_state = ST_PIXEL_BYTES;
            end
         end
         ST_PIXEL_BYTES: begin
            last_pos = wide_pixels ? 2'd3 : 2'd2;
            color_bytes[color_pos] = b;
            if (color_pos < last_pos) begin
               color_pos = color_pos + 2'd1;
            end else begin
               rep = (rle && !packet_raw) ? 32'(packet_left) : 32'd1;
               color_pos = '0;
               if (rep > pixels_left) rep = pixels_left;
               pixels_left -= rep;
               res = image_word(trd_pkg::KIND_PIXEL);
               res.fields.red          = color_bytes[2];
               res.fields.green        = color_bytes[1];
               res.fields.blue         = color_bytes[0];
               res.fields.alpha        = wide_pixels ? color_bytes[3] : 8'd0;
               res.fields.repeat_count = rep[7:0];
               res.done = (pixels_left == '0);
               emit = 1'b1;
               if (rle) begin
                  if (packet_raw && packet_left > 8'd0) packet_left = packet_left - 8'd1;
                  else packet_left = '0;
               end
               if (pixels_left == '0) parse_state = ST_IMAGE_DONE;
               else if (rle && packet_left == '0) parse_state = ST_PACKET_HEAD;
            end
         end
         default: ;
      endcase

      // end of stream: an unfinished image is truncated, then back to a fresh file
      if (eos) begin
         if (!failed && parse_state != ST_IMAGE_DONE && parse_state != ST_REJECTED) begin
            res = error_word(trd_pkg::ERR_TRUNCATED);
            emit = 1'b1;
         end
         clear_parser();
      end
      if (emit) predicted_words.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_word();
      tga_result_type          want;
      trd_pkg::rsp_fields_type got;
      got = rsp_tdata[76:0];
      if (predicted_words.size() == 0) begin
         $error("result word with nothing predicted: kind %0h, tdata %h", rsp_tuser, rsp_tdata);
         mismatches++;
      end else begin
         want = predicted_words.pop_front();
         check_field("kind", 32'(want.kind), 32'(rsp_tuser));
         check_field("red", 32'(want.fields.red), 32'(got.red));
         check_field("green", 32'(want.fields.green), 32'(got.green));
         check_field("blue", 32'(want.fields.blue), 32'(got.blue));
         check_field("alpha", 32'(want.fields.alpha), 32'(got.alpha));
         check_field("repeat_count", 32'(want.fields.repeat_count), 32'(got.repeat_count));
         check_field("image_width", 32'(want.fields.image_width), 32'(got.image_width));
         check_field("image_height", 32'(want.fields.image_height), 32'(got.image_height));
         check_field("has_alpha", 32'(want.fields.has_alpha), 32'(got.has_alpha));
         check_field("is_compressed", 32'(want.fields.is_compressed),
                     32'(got.is_compressed));
         check_field("error_code", 32'(want.fields.error_code), 32'(got.error_code));
         check_field("image_done", 32'(want.done), 32'(rsp_tlast));
         check_field("tdata_pad", 32'd0, 32'(rsp_tdata[79:77]));
      end
   endtask

   // results leave before the byte taken at the same edge can add one
   always @(posedge clock) begin
      if (reset) begin
         predicted_words.delete();
         clear_parser();
      end else begin
         if (rsp_tvalid && rsp_tready) check_word();
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
      end
      words_outstanding <= predicted_words.size();
   end

endmodule

// File: tb/sv/tb_tga_rle_image_decoder.sv
module tb_tga_rle_image_decoder;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side
   localparam int PHASE_BYTES   = 490;   // three idling phases, at least 1470 bytes in all

   logic                               clock;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata  = '0;
   logic                               req_tlast  = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [trd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [1:0]                         rsp_tuser;
   logic                               rsp_tlast;

   int mismatch_count;
   int words_outstanding;
   int src_idle_pct = 36;
   int dst_idle_pct = 80;
   int bytes_sent   = 0;
   int stall_cycles = 0;

   // file under construction: bit 8 is end_of_stream, bits 7:0 the byte
   logic [8:0] file_bytes [$];

   tga_rle_image_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tga_decode_checker u_decode_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= dst_idle_pct);
   end

   // watchdog: ends the run when the channels stay quiet too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one byte word, with random idle cycles in front of it
   task automatic send_word(input logic [8:0] w);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w[7:0];
      req_tlast  <= w[8];
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // sender holds off until every predicted result word has been taken
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
   endtask

   task automatic push_byte(input logic [7:0] b);
      file_bytes.push_back({1'b0, b});
   endtask

   task automatic add_header(input logic [7:0] type_code, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth);
      for (int i = 0; i < 12; i++) begin
         push_byte((i == int'(trd_pkg::POS_TYPE)) ? type_code : 8'd0);
      end
      push_byte(w[7:0]);
      push_byte(w[15:8]);
      push_byte(h[7:0]);
      push_byte(h[15:8]);
      push_byte(depth);
      push_byte(8'($urandom_range(255)));  // descriptor, ignored
   endtask

   task automatic add_pixel(input bit wide);
      repeat (wide ? 4 : 3) push_byte(8'($urandom_range(255)));
   endtask

   // pixel data; for rle a mix of runs and raw packets, with an oversize
   // packet header in place of the final packet when overflow is asked
   task automatic add_body(input bit rle, input bit wide, input int total,
                           input int run_pct, input bit overflow);
      int  left;
      int  cap;
      int  n;
      bit  is_run;
      left = total;
      if (!rle) begin
         repeat (total) add_pixel(wide);
      end else begin
         while (left > 0) begin
            cap = (left < 128) ? left : 128;
            is_run = ($urandom_range(99) < run_pct);
            // raw packets mostly short to keep files small
            if (!is_run && cap > 4 && $urandom_range(19) != 0) cap = 4;
            n = $urandom_range(cap, 1);
            if (overflow && n == left && left < 128) begin
               n = $urandom_range(128, left + 1);
               push_byte(is_run ? 8'(127 + n) : 8'(n - 1));
               add_pixel(wide);
               left = 0;
            end else begin
               push_byte(is_run ? 8'(127 + n) : 8'(n - 1));
               if (is_run) add_pixel(wide);
               else repeat (n) add_pixel(wide);
               left -= n;
            end
         end
      end
   endtask

   // append trailing bytes, mark end of stream and send the whole file
   task automatic ship_file(input int trailing);
      repeat (trailing) push_byte(8'($urandom_range(255)));
      file_bytes[file_bytes.size() - 1][8] = 1'b1;
      foreach (file_bytes[i]) send_word(file_bytes[i]);
      file_bytes.delete();
   endtask

   task automatic cut_file();
      int keep;
      if (file_bytes.size() > 1) begin
         keep = $urandom_range(file_bytes.size() - 1, 1);
         while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
   endtask

   task automatic run_directed_files();
      // smallest raw image, all-zero pixel
      add_header(trd_pkg::TYPE_RAW_CODE, 16'd1, 16'd1, trd_pkg::DEPTH_24);
      repeat (3) push_byte(8'h00);
      ship_file(0);
      // raw 32-bit, an all-ones pixel and a second pixel, then bytes after the image is done
      add_header(trd_pkg::TYPE_RAW_CODE, 16'd1, 16'd2, trd_pkg::DEPTH_32);
      repeat (4) push_byte(8'hff);
      push_byte(8'h12); push_byte(8'h34); push_byte(8'h56); push_byte(8'h78);
      ship_file(3);
      // longest run in one packet
      add_header(trd_pkg::TYPE_RLE_CODE, 16'd1, 16'd128, trd_pkg::DEPTH_32);
      push_byte(8'hff);
      add_pixel(1'b1);
      ship_file(0);
      // raw single, shortest run, raw pair
      add_header(trd_pkg::TYPE_RLE_CODE, 16'd4, 16'd1, trd_pkg::DEPTH_24);
      push_byte(8'h00); add_pixel(1'b0);
      push_byte(8'h80); add_pixel(1'b0);
      push_byte(8'h01); add_pixel(1'b0); add_pixel(1'b0);
      ship_file(0);
      // unknown image type
      add_header(8'd3, 16'd1, 16'd1, trd_pkg::DEPTH_24);
      ship_file(2);
      // zero width, then a bad depth
      add_header(trd_pkg::TYPE_RAW_CODE, 16'd0, 16'd5, trd_pkg::DEPTH_24);
      ship_file(1);
      add_header(trd_pkg::TYPE_RLE_CODE, 16'd2, 16'd2, 8'd16);
      ship_file(0);
      // packet larger than the image
      add_header(trd_pkg::TYPE_RLE_CODE, 16'd1, 16'd1, trd_pkg::DEPTH_24);
      push_byte(8'h81);
      add_pixel(1'b0);
      ship_file(0);
      // largest size, stream ends after one pixel
      add_header(trd_pkg::TYPE_RAW_CODE, 16'hffff, 16'hffff, trd_pkg::DEPTH_24);
      add_pixel(1'b0);
      ship_file(0);
      // stream that ends on its first byte
      push_byte(8'h00);
      ship_file(0);
   endtask

   task automatic make_random_file();
      int         pick;
      bit         rle;
      bit         wide;
      int         w;
      int         h;
      int         run_pct;
      int         p;
      logic [7:0] depth;
      logic [7:0] type_code;
      logic [7:0] good_depth;
      pick = $urandom_range(99);
      rle  = $urandom_range(1);
      wide = $urandom_range(1);
      run_pct = 50;
      if ($urandom_range(9) == 0) begin
         // tall image so long runs fit
         w = $urandom_range(2, 1);
         h = $urandom_range(128, 64);
         rle = 1'b1;
         run_pct = 90;
      end else begin
         w = $urandom_range(4, 1);
         h = $urandom_range(4, 1);
      end
      type_code  = rle ? trd_pkg::TYPE_RLE_CODE : trd_pkg::TYPE_RAW_CODE;
      good_depth = wide ? trd_pkg::DEPTH_32 : trd_pkg::DEPTH_24;
      if (pick < 70) begin
         // well-formed image, some with trailing bytes
         add_header(type_code, 16'(w), 16'(h), good_depth);
         add_body(rle, wide, w * h, run_pct, 1'b0);
         ship_file((pick < 55) ? 0 : $urandom_range(4, 1));
      end else if (pick < 80) begin
         // cut short, sometimes with a size from the full range
         if ($urandom_range(1) == 0) begin
            add_header(type_code, 16'($urandom_range(65535, 1)),
                       16'($urandom_range(65535, 1)), good_depth);
            add_body(rle, wide, $urandom_range(4, 1), run_pct, 1'b0);
         end else begin
            add_header(type_code, 16'(w), 16'(h), good_depth);
            add_body(rle, wide, w * h, run_pct, 1'b0);
            cut_file();
         end
         ship_file(0);
      end else if (pick < 87) begin
         // damaged fixed header, or plain noise
         if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(30, 1)) push_byte(8'($urandom_range(255)));
         end else begin
            add_header(type_code, 16'(w), 16'(h), good_depth);
            p = $urandom_range(11);
            file_bytes[p][7:0] = 8'($urandom_range(255, 1));
         end
         ship_file($urandom_range(6));
      end else if (pick < 93) begin
         // zero width, zero height or unsupported depth
         depth = good_depth;
         case ($urandom_range(2))
            0: w = 0;
            1: h = 0;
            default: begin
               w = $urandom_range(65535, 1);
               h = $urandom_range(65535, 1);
               do depth = 8'($urandom_range(255));
               while (depth == trd_pkg::DEPTH_24 || depth == trd_pkg::DEPTH_32);
            end
         endcase
         add_header(type_code, 16'(w), 16'(h), depth);
         ship_file($urandom_range(4));
      end else begin
         // rle packet that needs more pixels than are left
         add_header(trd_pkg::TYPE_RLE_CODE, 16'(w), 16'(h), good_depth);
         add_body(1'b1, wide, w * h, run_pct, 1'b1);
         ship_file($urandom_range(3));
      end
   endtask

   task automatic run_random_files(input int byte_goal);
      int goal;
      goal = bytes_sent + byte_goal;
      while (bytes_sent < goal) begin
         make_random_file();
         if ($urandom_range(19) == 0) wait_for_drain();
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed_files();
      wait_for_drain();
      // sender mostly active, receiver mostly stalled
      run_random_files(PHASE_BYTES);
      // the other way round
      src_idle_pct = 80;
      dst_idle_pct = 36;
      run_random_files(PHASE_BYTES);
      // full rate on both sides
      src_idle_pct = 0;
      dst_idle_pct = 0;
      run_random_files(PHASE_BYTES);
      // wait for any stray result word to show up
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/trd_pkg.sv
design/tga_rle_image_decoder.sv
tb/sv/tga_decode_checker.sv
tb/sv/tb_tga_rle_image_decoder.sv
